// File: hw/rtl/rglm_pkg.sv
package rglm_pkg;

  localparam int NUM_LABELS  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int GROUP_WIDTH = 16;

  localparam int IDX_W = $clog2(NUM_LABELS);
  localparam int LC_W  = 5;

  localparam int IN_DATA_W  = ((GROUP_WIDTH + IDX_W + 7) / 8) * 8;
  localparam int OUT_FLD_W  = GROUP_WIDTH + IDX_W + COUNT_WIDTH + IDX_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [LC_W-1:0]        LC_RESET  = LC_W'(NUM_LABELS);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_MODE,
    ST_MODE_LAST,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // Clamp the bin count register to 1 .. NUM_LABELS.
  function automatic logic [LC_W:0] bins_in_use(input logic [LC_W-1:0] lc);
    logic [LC_W:0] n;
    n = {1'b0, lc};
    if (lc == '0) begin
      n = (LC_W+1)'(1);
    end else if (n > (LC_W+1)'(NUM_LABELS)) begin
      n = (LC_W+1)'(NUM_LABELS);
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/run_grouped_label_mode_unit.sv
// Channel | Dir | Beat fields (lowest bits first)                       | Marker
// --------+-----+-------------------------------------------------------+----------------
// in_     | in  | tdata: group_id[15:0], label[19:16], zero pad [23:20] | tlast=final_item
// out_    | out | tdata: run_group, bin_index, bin_count, mode_label     | tlast=run_last,
//         |     |                                                       | tuser=stream_last
// cfg_    | in  | wdata: label_count (5 bits), written when cfg_we high |
//
// An item inside a run passes through the accept in idle, a histogram read and a
// write-back on the histogram memory. Closing a run of n bins adds a mode scan over the
// n bins and, for each emitted bin, a read and then a load into the output register, and
// it waits while the output stalls. Reset (rst_n low, synchronous) clears control state
// and the per-bin valid bits and holds in_tready low; no clearing pass runs, a bin whose
// valid bit is low reads as 0.
module run_grouped_label_mode_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // group_id, label, zero pad
  input  logic [rglm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // run_group, bin_index, bin_count, mode_label
  output logic [rglm_pkg::OUT_DATA_W-1:0] out_tdata,
  // stream_last
  output logic                           out_tuser,
  output logic                           out_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_we,
  input  logic [rglm_pkg::LC_W-1:0]       cfg_wdata
);
  import rglm_pkg::*;

  // Histogram storage: one write port, one registered read port.
  logic [COUNT_WIDTH-1:0] hist_mem [NUM_LABELS];
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [NUM_LABELS-1:0]  valid_r;

  state_t state_r, state_nxt;

  logic [LC_W-1:0]        label_count_r;
  logic [GROUP_WIDTH-1:0] item_grp_r;
  logic [IDX_W-1:0]       item_lab_r;
  logic                   item_fin_r;
  logic [GROUP_WIDTH-1:0] open_group_r;
  logic                   run_open_r;
  logic                   emit_end_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [COUNT_WIDTH-1:0] best_count_r;
  logic [IDX_W-1:0]       best_label_r;

  logic [GROUP_WIDTH-1:0] out_group_r;
  logic [IDX_W-1:0]       out_bin_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic [IDX_W-1:0]       out_mode_r;
  logic                   out_last_r;
  logic                   out_slast_r;
  logic                   out_valid_r;

  logic [LC_W:0]          n_bins;
  logic [IDX_W-1:0]       last_idx;
  logic                   idx_is_last;
  logic [COUNT_WIDTH-1:0] bin_val;
  logic                   lab_in_use;
  logic                   cnt_do;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_ra;
  logic                   in_fire;
  logic                   grp_change;
  logic                   out_free;

  logic [GROUP_WIDTH-1:0] in_grp;
  logic [IDX_W-1:0]       in_lab;

  assign in_grp = in_tdata[GROUP_WIDTH-1:0];
  assign in_lab = in_tdata[GROUP_WIDTH +: IDX_W];

  assign n_bins      = bins_in_use(label_count_r);
  assign last_idx    = IDX_W'(n_bins - (LC_W+1)'(1));
  assign idx_is_last = (idx_r == last_idx);
  // Mask stale entries of a run that has been reopened.
  assign bin_val     = valid_r[pend_idx_r] ? rdata_r : '0;
  assign lab_in_use  = ({{(LC_W+1-IDX_W){1'b0}}, item_lab_r} < n_bins);
  assign cnt_do      = (state_r == ST_CNT_WR) && lab_in_use && (bin_val != COUNT_MAX);
  assign in_fire     = in_tvalid && in_tready;
  assign grp_change  = run_open_r && (in_grp != open_group_r);
  assign out_free    = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = grp_change ? ST_MODE : ST_CNT_RD;
        end
      end
      ST_CNT_RD: state_nxt = ST_CNT_WR;
      ST_CNT_WR: state_nxt = item_fin_r ? ST_MODE : ST_IDLE;
      ST_MODE: begin
        if (idx_is_last) begin
          state_nxt = ST_MODE_LAST;
        end
      end
      ST_MODE_LAST: state_nxt = ST_EMIT_RD;
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        if (idx_is_last) begin
          state_nxt = emit_end_r ? ST_IDLE : ST_CNT_RD;
        end else begin
          state_nxt = ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and memory read controls. Accesses are serialized by the state
  // sequence, so a read never meets a write to the same bin in flight.
  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_ra    = idx_r;
    case (state_r)
      ST_IDLE:    in_tready = rst_n;
      ST_CNT_RD: begin
        mem_re = 1'b1;
        mem_ra = item_lab_r;
      end
      ST_MODE:    mem_re = 1'b1;
      ST_EMIT_RD: mem_re = out_free;
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Histogram memory.
  always_ff @(posedge clk) begin
    if (cnt_do) begin
      hist_mem[item_lab_r] <= bin_val + COUNT_WIDTH'(1);
    end
    if (mem_re) begin
      rdata_r <= hist_mem[mem_ra];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      label_count_r <= LC_RESET;
      valid_r       <= '0;
      open_group_r  <= '0;
      run_open_r    <= 1'b0;
      emit_end_r    <= 1'b0;
      idx_r         <= '0;
      pend_r        <= 1'b0;
      best_count_r  <= '0;
      best_label_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= mem_re;
      if (cfg_we) begin
        label_count_r <= cfg_wdata;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && grp_change) begin
            emit_end_r   <= 1'b0;
            idx_r        <= '0;
            best_count_r <= '0;
            best_label_r <= '0;
          end
        end
        ST_CNT_RD: begin
          // Open a run: drop every bin at once.
          if (!run_open_r) begin
            valid_r      <= '0;
            open_group_r <= item_grp_r;
            run_open_r   <= 1'b1;
          end
        end
        ST_CNT_WR: begin
          if (cnt_do) begin
            valid_r[item_lab_r] <= 1'b1;
          end
          if (item_fin_r) begin
            emit_end_r   <= 1'b1;
            idx_r        <= '0;
            best_count_r <= '0;
            best_label_r <= '0;
          end
        end
        ST_MODE, ST_MODE_LAST: begin
          if (state_r == ST_MODE) begin
            idx_r <= idx_is_last ? '0 : idx_r + IDX_W'(1);
          end
          // Strict compare keeps the lowest bin on a tie.
          if (pend_r && (bin_val > best_count_r)) begin
            best_count_r <= bin_val;
            best_label_r <= pend_idx_r;
          end
        end
        ST_EMIT_LD: begin
          out_valid_r <= 1'b1;
          idx_r       <= idx_is_last ? '0 : idx_r + IDX_W'(1);
          if (idx_is_last) begin
            run_open_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      pend_idx_r <= mem_ra;
    end
    if (in_fire) begin
      item_grp_r <= in_grp;
      item_lab_r <= in_lab;
      item_fin_r <= in_tlast;
    end
    if (state_r == ST_EMIT_LD) begin
      out_group_r <= open_group_r;
      out_bin_r   <= pend_idx_r;
      out_count_r <= bin_val;
      out_mode_r  <= best_label_r;
      out_last_r  <= idx_is_last;
      out_slast_r <= idx_is_last && emit_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_slast_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FLD_W){1'b0}},
                       out_mode_r, out_count_r, out_bin_r, out_group_r};

  // The histogram is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && cnt_do))
    else $error("histogram read and write in the same cycle");

  // Every emitted bin is bounded by the mode count found in the scan.
  a_mode_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD) |-> (bin_val <= best_count_r))
    else $error("emitted bin exceeds mode count");

  // The mode label never lies beyond the last emitted bin.
  a_mode_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_mode_r <= out_bin_r))
    else $error("mode label beyond last bin");

  // Closing a run leaves no run open.
  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_LD && idx_is_last) |=> !run_open_r)
    else $error("run still open after emission");

  // Stream end is only flagged on the last bin of a run.
  a_slast_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_slast_r || out_last_r))
    else $error("stream end without run end");

endmodule
